// ----- design/assert_macros.svh -----
// Assertion macros used by the checker in rrs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define RRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define RRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/rrs_pkg.sv -----
`timescale 1ns / 1ps

package rrs_pkg;

	// Item kinds
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_SLOT  = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_WIDTH = 8;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_WIDTH  = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_HEIGHT = 8'd1;

	localparam logic [7:0] SCREEN_WIDTH_RESET  = 8'd128;
	localparam logic [7:0] SCREEN_HEIGHT_RESET = 8'd160;

	// Display commands
	localparam logic [7:0] DISP_COLUMN_WINDOW = 8'h2A;
	localparam logic [7:0] DISP_ROW_WINDOW    = 8'h2B;
	localparam logic [7:0] DISP_MEMORY_WRITE  = 8'h2C;

	// Header positions
	localparam logic [3:0] HDR_COL_CMD   = 4'd0;
	localparam logic [3:0] HDR_X0        = 4'd2;
	localparam logic [3:0] HDR_X1        = 4'd4;
	localparam logic [3:0] HDR_ROW_CMD   = 4'd5;
	localparam logic [3:0] HDR_Y0        = 4'd7;
	localparam logic [3:0] HDR_Y1        = 4'd9;
	localparam logic [3:0] HDR_MEM_CMD   = 4'd10;
	localparam logic [3:0] HEADER_LENGTH = 4'd11;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  center_x;
		logic [7:0]  center_y;
		logic [7:0]  inner_radius;
		logic [7:0]  outer_radius;
		logic [15:0] background_color;
		logic [15:0] rim_color;
	} rrs_item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       is_command;
		logic       last;
	} rrs_word_t;

endpackage

// ----- design/rrs_pixel.sv -----
`timescale 1ns / 1ps

module rrs_pixel (
	input  logic [8:0]  row,
	input  logic [8:0]  col,
	input  logic [7:0]  radius,
	input  logic [15:0] outer_sq,
	input  logic [15:0] inner_sq,
	output logic        rim_hit
);
	logic [8:0]  r_ext;
	logic [8:0]  dr_full;
	logic [8:0]  dc_full;
	logic [15:0] dr_sq;
	logic [15:0] dc_sq;
	logic [16:0] sq_sum;

	assign r_ext = {1'b0, radius};

	// Offset from centre, both sides of the box fold onto one
	assign dr_full = (row >= r_ext) ? (row - r_ext) : (r_ext - row);
	assign dc_full = (col >= r_ext) ? (col - r_ext) : (r_ext - col);

	assign dr_sq  = {8'd0, dr_full[7:0]} * {8'd0, dr_full[7:0]};
	assign dc_sq  = {8'd0, dc_full[7:0]} * {8'd0, dc_full[7:0]};
	assign sq_sum = {1'b0, dr_sq} + {1'b0, dc_sq};

	assign rim_hit = (sq_sum <= {1'b0, outer_sq}) && (sq_sum >= {1'b0, inner_sq});

endmodule

// ----- design/rrs_seq.sv -----
`timescale 1ns / 1ps

module rrs_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  rrs_pkg::rrs_item_t item,
	input  logic [7:0]         screen_width,
	input  logic [7:0]         screen_height,
	output rrs_pkg::rrs_word_t word
);
	import rrs_pkg::*;

	logic        active_q;
	logic [3:0]  hdr_idx_q;
	logic [8:0]  row_q;
	logic [8:0]  col_q;
	logic        low_q;
	logic [7:0]  cx_q;
	logic [7:0]  cy_q;
	logic [7:0]  r_q;
	logic [15:0] inner_sq_q;
	logic [15:0] outer_sq_q;
	logic [15:0] bg_q;
	logic [15:0] rim_q;

	logic        off_screen;
	logic        start_ok;
	logic        slot_ok;
	logic        in_header;
	logic [8:0]  sum_x;
	logic [8:0]  sum_y;
	logic [7:0]  ro_x;
	logic [7:0]  ro_y;
	logic [8:0]  span;
	logic        rim_hit;
	logic [15:0] color;
	logic [7:0]  hdr_byte;
	logic        hdr_cmd;
	logic        row_end;
	logic        col_end;

	// Start decision and radius clamp, width first then height
	assign off_screen = (item.center_x >= screen_width) || (item.center_y >= screen_height);
	assign start_ok   = step && (item.cmd == CMD_START) && !active_q && !off_screen;
	assign slot_ok    = step && (item.cmd == CMD_SLOT) && active_q;

	assign sum_x = {1'b0, item.center_x} + {1'b0, item.outer_radius};
	assign ro_x  = (sum_x >= ({1'b0, screen_width} + 9'd1)) ?
		(screen_width - item.center_x) : item.outer_radius;
	assign sum_y = {1'b0, item.center_y} + {1'b0, ro_x};
	assign ro_y  = (sum_y >= ({1'b0, screen_height} + 9'd1)) ?
		(screen_height - item.center_y) : ro_x;

	assign in_header = (hdr_idx_q < HEADER_LENGTH);
	assign span      = {r_q, 1'b0};
	assign col_end   = (col_q >= span);
	assign row_end   = (row_q >= span);

	always_comb begin
		hdr_byte = 8'h00;
		hdr_cmd  = 1'b0;
		case (hdr_idx_q)
			HDR_COL_CMD: begin
				hdr_byte = DISP_COLUMN_WINDOW;
				hdr_cmd  = 1'b1;
			end
			HDR_X0:      hdr_byte = cx_q - r_q;
			HDR_X1:      hdr_byte = cx_q + r_q;
			HDR_ROW_CMD: begin
				hdr_byte = DISP_ROW_WINDOW;
				hdr_cmd  = 1'b1;
			end
			HDR_Y0:      hdr_byte = cy_q - r_q;
			HDR_Y1:      hdr_byte = cy_q + r_q;
			HDR_MEM_CMD: begin
				hdr_byte = DISP_MEMORY_WRITE;
				hdr_cmd  = 1'b1;
			end
			default: begin
				hdr_byte = 8'h00;
				hdr_cmd  = 1'b0;
			end
		endcase
	end

	rrs_pixel u_pixel (
		.row      (row_q),
		.col      (col_q),
		.radius   (r_q),
		.outer_sq (outer_sq_q),
		.inner_sq (inner_sq_q),
		.rim_hit  (rim_hit)
	);

	assign color = rim_hit ? rim_q : bg_q;

	always_comb begin
		word.valid      = slot_ok;
		word.is_command = 1'b0;
		word.last       = 1'b0;
		if (in_header) begin
			word.data_byte  = hdr_byte;
			word.is_command = hdr_cmd;
		end else begin
			word.data_byte = low_q ? color[7:0] : color[15:8];
			word.last      = low_q && col_end && row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			hdr_idx_q <= 4'd0;
			row_q     <= 9'd0;
			col_q     <= 9'd0;
			low_q     <= 1'b0;
		end else if (start_ok) begin
			active_q  <= 1'b1;
			hdr_idx_q <= 4'd0;
			row_q     <= 9'd0;
			col_q     <= 9'd0;
			low_q     <= 1'b0;
		end else if (slot_ok) begin
			if (in_header) begin
				hdr_idx_q <= hdr_idx_q + 4'd1;
			end else if (!low_q) begin
				low_q <= 1'b1;
			end else begin
				low_q <= 1'b0;
				if (col_end) begin
					col_q <= 9'd0;
					if (row_end) begin
						row_q     <= 9'd0;
						active_q  <= 1'b0;
						hdr_idx_q <= 4'd0;
					end else begin
						row_q <= row_q + 9'd1;
					end
				end else begin
					col_q <= col_q + 9'd1;
				end
			end
		end
	end

	// Latch the drawing setup
	always_ff @(posedge clk) begin
		if (start_ok) begin
			cx_q       <= item.center_x;
			cy_q       <= item.center_y;
			r_q        <= ro_y;
			inner_sq_q <= {8'd0, item.inner_radius} * {8'd0, item.inner_radius};
			outer_sq_q <= {8'd0, ro_y} * {8'd0, ro_y};
			bg_q       <= item.background_color;
			rim_q      <= item.rim_color;
		end
	end

endmodule

// ----- design/ring_raster_stream.sv -----
`timescale 1ns / 1ps
// Ring raster streamer: a start word (cmd low) latches a ring centre, inner and
// outer radii and two RGB565 colours; each slot word (cmd high) then yields one
// display byte with its command flag. The stream is the column window command
// and four bytes, the row window command and four bytes, the memory-write
// command, then two colour bytes (high first) per pixel, row by row over the
// square box around the centre, with last set on the final byte. A start is
// dropped while a drawing runs or when the centre lies off screen; the outer
// radius is clamped to the screen width, then to the height. The block takes
// one word per clock while in_stall is low; each word is decoded and its byte
// formed between the drawing state registers and the output register, where
// the longest path is the squared-distance compare (two 8x8 multiplies, an add
// and two compares). in_stall rises only while the output register holds a
// word that out_stall is holding back. Write screen_width (index 0) and
// screen_height (index 1) only between drawings; cfg_ready is always high and
// writes to other indexes are dropped.

module ring_raster_stream (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [7:0]                          center_x,
	input  logic [7:0]                          center_y,
	input  logic [7:0]                          inner_radius,
	input  logic [7:0]                          outer_radius,
	input  logic [15:0]                         background_color,
	input  logic [15:0]                         rim_color,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          data_byte,
	output logic                                is_command,
	output logic                                last,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rrs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [7:0]                          cfg_data
);
	import rrs_pkg::*;

	logic [7:0] screen_width_q;
	logic [7:0] screen_height_q;
	logic       out_valid_q;
	logic [7:0] data_byte_q;
	logic       is_command_q;
	logic       last_q;
	logic       step;
	rrs_item_t  item;
	rrs_word_t  word;

	// Configuration: always ready, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the input only while the output register is full and held back
	assign in_stall = out_valid_q && out_stall;
	assign step     = in_valid && !in_stall;

	assign item.cmd              = cmd;
	assign item.center_x         = center_x;
	assign item.center_y         = center_y;
	assign item.inner_radius     = inner_radius;
	assign item.outer_radius     = outer_radius;
	assign item.background_color = background_color;
	assign item.rim_color        = rim_color;

	rrs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.item          (item),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.word          (word)
	);

	// Output register: load a new word, or drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (word.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word.valid) begin
			data_byte_q  <= word.data_byte;
			is_command_q <= word.is_command;
			last_q       <= word.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = data_byte_q;
	assign is_command = is_command_q;
	assign last       = last_q;

endmodule

// ----- design/rrs_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] data_byte,
	input logic       is_command,
	input logic       last
);
	import rrs_pkg::*;

	logic known_cmd;

	assign known_cmd = (data_byte == DISP_COLUMN_WINDOW) || (data_byte == DISP_ROW_WINDOW) ||
		(data_byte == DISP_MEMORY_WRITE);

	// A held word keeps its byte
	`RRS_ASSERT_NXT(a_hold_word, clk, arst_n, out_valid && out_stall, out_valid && $stable(data_byte))

	// Input is only held back by a full, stalled output
	`RRS_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// The final byte is always colour data
	`RRS_ASSERT_IMP(a_last_is_data, clk, arst_n, out_valid && last, !is_command)

	// Command bytes are only the three window and write commands
	`RRS_ASSERT_IMP(a_cmd_code, clk, arst_n, out_valid && is_command, known_cmd)

endmodule

bind ring_raster_stream rrs_checker u_rrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.data_byte  (data_byte),
	.is_command (is_command),
	.last       (last)
);

// ----- verif/ring_stream_checker.sv -----
`timescale 1ns / 1ps

module ring_stream_checker (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                cmd,
	input  logic [7:0]                          center_x,
	input  logic [7:0]                          center_y,
	input  logic [7:0]                          inner_radius,
	input  logic [7:0]                          outer_radius,
	input  logic [15:0]                         background_color,
	input  logic [15:0]                         rim_color,

	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [7:0]                          data_byte,
	input  logic                                is_command,
	input  logic                                last,

	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [rrs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [7:0]                          cfg_data,

	output int                                  mismatches,
	output int                                  outstanding
);

	import rrs_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_command;
		logic       last;
	} disp_byte_t;

	// Screen size as last written, and the drawing in flight
	logic [7:0]  scr_w;
	logic [7:0]  scr_h;
	logic        busy;
	logic [3:0]  hdr_pos;
	logic [9:0]  row_off;
	logic [9:0]  col_off;
	logic        low_half;
	logic [7:0]  cx_q;
	logic [7:0]  cy_q;
	logic [7:0]  rad_q;
	logic [16:0] hole_sq;
	logic [15:0] bg_q;
	logic [15:0] rim_q;

	disp_byte_t due_bytes[$];

	task automatic report(input string what, input int got, input int want);
		mismatches++;
		$display("At %0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Advance the drawing by one accepted word; queue the display byte it yields.
	task automatic raster_step(input logic kind, input logic [7:0] cx, input logic [7:0] cy,
			input logic [7:0] ri, input logic [7:0] ro_in, input logic [15:0] bg,
			input logic [15:0] rim);
		int unsigned ro;
		int unsigned r;
		int unsigned span;
		int unsigned row_u;
		int unsigned col_u;
		int unsigned dr;
		int unsigned dc;
		int unsigned sq_sum;
		logic [15:0] colour;
		disp_byte_t w;
		if (kind == CMD_START) begin
			if (busy || cx >= scr_w || cy >= scr_h)
				return;
			// clamp to the width first, then to the height
			ro = {24'd0, ro_in};
			if ({24'd0, cx} + ro >= {24'd0, scr_w} + 32'd1)
				ro = {24'd0, scr_w} - {24'd0, cx};
			if ({24'd0, cy} + ro >= {24'd0, scr_h} + 32'd1)
				ro = {24'd0, scr_h} - {24'd0, cy};
			cx_q = cx;
			cy_q = cy;
			rad_q = ro[7:0];
			hole_sq = {9'd0, ri} * {9'd0, ri};
			bg_q = bg;
			rim_q = rim;
			hdr_pos = '0;
			row_off = '0;
			col_off = '0;
			low_half = 1'b0;
			busy = 1'b1;
			return;
		end
		if (!busy)
			return;
		w = '0;
		if (hdr_pos < HEADER_LENGTH) begin
			case (hdr_pos)
				HDR_COL_CMD: begin
					w.data_byte = DISP_COLUMN_WINDOW;
					w.is_command = 1'b1;
				end
				HDR_X0: w.data_byte = cx_q - rad_q;
				HDR_X1: w.data_byte = cx_q + rad_q;
				HDR_ROW_CMD: begin
					w.data_byte = DISP_ROW_WINDOW;
					w.is_command = 1'b1;
				end
				HDR_Y0: w.data_byte = cy_q - rad_q;
				HDR_Y1: w.data_byte = cy_q + rad_q;
				HDR_MEM_CMD: begin
					w.data_byte = DISP_MEMORY_WRITE;
					w.is_command = 1'b1;
				end
				default: w.data_byte = 8'h00;
			endcase
			hdr_pos++;
		end else begin
			r = {24'd0, rad_q};
			span = 2 * r;
			row_u = {22'd0, row_off};
			col_u = {22'd0, col_off};
			dr = (row_u >= r) ? row_u - r : r - row_u;
			dc = (col_u >= r) ? col_u - r : r - col_u;
			sq_sum = dr * dr + dc * dc;
			colour = (sq_sum <= r * r && sq_sum >= {15'd0, hole_sq}) ? rim_q : bg_q;
			if (!low_half) begin
				w.data_byte = colour[15:8];
				low_half = 1'b1;
			end else begin
				w.data_byte = colour[7:0];
				low_half = 1'b0;
				if (col_u >= span) begin
					col_off = '0;
					if (row_u >= span) begin
						w.last = 1'b1;
						row_off = '0;
						busy = 1'b0;
						hdr_pos = '0;
					end else begin
						row_off++;
					end
				end else begin
					col_off++;
				end
			end
		end
		due_bytes.push_back(w);
	endtask

	task automatic check_word();
		disp_byte_t w;
		if (due_bytes.size() == 0) begin
			report("display word with none due, data_byte", int'(data_byte), 0);
			return;
		end
		w = due_bytes.pop_front();
		if (data_byte !== w.data_byte)
			report("data_byte", int'(data_byte), int'(w.data_byte));
		if (is_command !== w.is_command)
			report("is_command", int'(is_command), int'(w.is_command));
		if (last !== w.last)
			report("last", int'(last), int'(w.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w = SCREEN_WIDTH_RESET;
			scr_h = SCREEN_HEIGHT_RESET;
			busy = 1'b0;
			hdr_pos = '0;
			row_off = '0;
			col_off = '0;
			low_half = 1'b0;
			cx_q = '0;
			cy_q = '0;
			rad_q = '0;
			hole_sq = '0;
			bg_q = '0;
			rim_q = '0;
			due_bytes.delete();
			outstanding <= 0;
		end else begin
			// compare first: a word leaving now never stems from a word taken now
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall)
				raster_step(cmd, center_x, center_y, inner_radius, outer_radius,
					background_color, rim_color);
			// a write taken now only affects words taken later
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_w = cfg_data;
					REG_SCREEN_HEIGHT: scr_h = cfg_data;
					default: ;
				endcase
			end
			outstanding <= due_bytes.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

	import rrs_pkg::*;

	// Register indexes past the end of the list; writes there must be dropped
	localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX_LOW = 8'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX_TOP = 8'hFF;
	// Words of drawing traffic per random phase
	localparam int PHASE_ITEMS = 90;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = CMD_SLOT;
	logic [7:0]  center_x = '0;
	logic [7:0]  center_y = '0;
	logic [7:0]  inner_radius = '0;
	logic [7:0]  outer_radius = '0;
	logic [15:0] background_color = '0;
	logic [15:0] rim_color = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic        is_command;
	logic        last;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	int mismatches;
	int outstanding;

	// Stimulus-side view of the screen size, used only to pace the drawings
	logic [7:0] screen_w = SCREEN_WIDTH_RESET;
	logic [7:0] screen_h = SCREEN_HEIGHT_RESET;
	int gap_pct = 0;
	int stall_pct = 0;
	int last_count = 0;
	int work_items = 0;

	ring_raster_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.center_x(center_x),
		.center_y(center_y),
		.inner_radius(inner_radius),
		.outer_radius(outer_radius),
		.background_color(background_color),
		.rim_color(rim_color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.is_command(is_command),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ring_stream_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.center_x(center_x),
		.center_y(center_y),
		.inner_radius(inner_radius),
		.outer_radius(outer_radius),
		.background_color(background_color),
		.rim_color(rim_color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.is_command(is_command),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold back the display side at random, at the rate the phase asks
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Count closing words as they leave; the stimulus uses this to tell when
	// a drawing is over. Update by NBA so a reader at the edge sees the old count.
	always @(posedge clk) begin
		if (out_valid && !out_stall && last)
			last_count <= last_count + 1;
	end

	// Hard stop in case the handshakes lock up
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic rrs_item_t make_item(input logic kind, input logic [7:0] cx,
			input logic [7:0] cy, input logic [7:0] ri, input logic [7:0] ro,
			input logic [15:0] bg, input logic [15:0] rim);
		rrs_item_t it;
		it.cmd = kind;
		it.center_x = cx;
		it.center_y = cy;
		it.inner_radius = ri;
		it.outer_radius = ro;
		it.background_color = bg;
		it.rim_color = rim;
		return it;
	endfunction

	// Random start word: mostly on screen, small radii unless the screen itself
	// keeps the clamped radius small.
	function automatic rrs_item_t random_start(input bit wide);
		rrs_item_t it;
		it.cmd = CMD_START;
		if ($urandom_range(0, 9) == 0)
			it.center_x = 8'($urandom_range(int'(screen_w), 255));
		else
			it.center_x = 8'($urandom_range(0, int'(screen_w) - 1));
		if ($urandom_range(0, 9) == 0)
			it.center_y = 8'($urandom_range(int'(screen_h), 255));
		else
			it.center_y = 8'($urandom_range(0, int'(screen_h) - 1));
		it.inner_radius = $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) :
			8'($urandom_range(0, 255));
		it.outer_radius = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4));
		it.background_color = 16'($urandom_range(0, 16'hFFFF));
		it.rim_color = 16'($urandom_range(0, 16'hFFFF));
		return it;
	endfunction

	// Offer one word, after a random gap, and hold it until taken. Valid is
	// left high: the next call or quiet_inputs moves it at the next falling edge.
	task automatic send_item(input rrs_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		center_x <= it.center_x;
		center_y <= it.center_y;
		inner_radius <= it.inner_radius;
		outer_radius <= it.outer_radius;
		background_color <= it.background_color;
		rim_color <= it.rim_color;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic quiet_inputs();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SCREEN_WIDTH:  screen_w = value;
			REG_SCREEN_HEIGHT: screen_h = value;
			default: ;
		endcase
	endtask

	// Drain the block, let its pipeline settle, then change the screen size.
	task automatic reconfigure(input logic [7:0] w, input logic [7:0] h);
		quiet_inputs();
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send a start word; if it opens a drawing, feed slot words until the
	// closing word leaves. stray_at >= 0 slips in a start word after that many
	// slots, well inside the header, where it must be dropped.
	task automatic draw_ring(input rrs_item_t st, input int stray_at);
		int seen;
		int sent;
		rrs_item_t slot;
		send_item(st);
		if (st.center_x >= screen_w || st.center_y >= screen_h)
			return;
		work_items++;
		seen = last_count;
		sent = 0;
		while (last_count == seen) begin
			if (sent == stray_at)
				send_item(random_start(1'b1));
			slot = random_start(1'b1);
			slot.cmd = CMD_SLOT;
			send_item(slot);
			sent++;
			work_items++;
		end
	endtask

	initial begin
		int base;
		int waited;
		logic [7:0] w;
		logic [7:0] h;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset screen size, no idling
		// slot with nothing to draw: no word
		send_item(make_item(CMD_SLOT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
		// centre just off the right edge, then just off the bottom
		draw_ring(make_item(CMD_START, 8'd128, 8'd0, 8'd0, 8'd2, 16'h0000, 16'hFFFF), -1);
		draw_ring(make_item(CMD_START, 8'd5, 8'd160, 8'd0, 8'd2, 16'h0000, 16'hFFFF), -1);
		send_item(make_item(CMD_SLOT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000));
		// single pixel at the corner, rim colour
		draw_ring(make_item(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 16'hFFFF), -1);
		// bottom right corner, radius clamped to one, hole larger than the ring
		draw_ring(make_item(CMD_START, 8'd127, 8'd159, 8'd255, 8'd255, 16'hFFFF, 16'h0000), -1);
		// window start coordinates wrap below zero
		draw_ring(make_item(CMD_START, 8'd0, 8'd0, 8'd2, 8'd3, 16'hA5A5, 16'h5A5A), 0);
		// a fuller ring, with a start dropped while it runs
		draw_ring(make_item(CMD_START, 8'd64, 8'd80, 8'd3, 8'd6, 16'h1234, 16'hFEDC), 5);
		// clamp by the width, then tighter by the height
		draw_ring(make_item(CMD_START, 8'd100, 8'd155, 8'd5, 8'd200, 16'h0F0F, 16'hF0F0), 7);
		draw_ring(make_item(CMD_START, 8'd126, 8'd10, 8'd1, 8'd255, 16'h8001, 16'h7FFE), -1);

		// zero width: every start dropped
		reconfigure(8'd0, SCREEN_HEIGHT_RESET);
		draw_ring(make_item(CMD_START, 8'd0, 8'd0, 8'd0, 8'd1, 16'h0000, 16'hFFFF), -1);
		send_item(make_item(CMD_SLOT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000));
		// restore, then poke indexes past the list: the width must stay at 128
		reconfigure(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
		write_reg(SPARE_INDEX_LOW, 8'h01);
		write_reg(SPARE_INDEX_TOP, 8'hFF);
		@(negedge clk);
		cfg_valid <= 1'b0;
		draw_ring(make_item(CMD_START, 8'd100, 8'd100, 8'd0, 8'd2, 16'hC3C3, 16'h3C3C), -1);

		// widest screen: clamp to one at the far corner, 255 lies off screen
		reconfigure(8'd255, 8'd255);
		draw_ring(make_item(CMD_START, 8'd255, 8'd0, 8'd0, 8'd1, 16'h0000, 16'hFFFF), -1);
		draw_ring(make_item(CMD_START, 8'd254, 8'd254, 8'd0, 8'd255, 16'h00FF, 16'hFF00), -1);

		// narrowest screen: one pixel on screen, window wraps on both axes
		reconfigure(8'd1, 8'd1);
		draw_ring(make_item(CMD_START, 8'd1, 8'd0, 8'd0, 8'd1, 16'h0000, 16'hFFFF), -1);
		draw_ring(make_item(CMD_START, 8'd0, 8'd1, 8'd0, 8'd1, 16'h0000, 16'hFFFF), -1);
		draw_ring(make_item(CMD_START, 8'd0, 8'd0, 8'd1, 8'd255, 16'h5555, 16'hAAAA), 2);

		// Random part: phases cycle through the idling modes and screen sizes
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin w = SCREEN_WIDTH_RESET; h = SCREEN_HEIGHT_RESET; end
				1: begin w = 8'd255; h = 8'd255; end
				2: begin w = 8'd1; h = 8'd1; end
				3: begin w = 8'd6; h = 8'd5; end
				4: begin w = 8'($urandom_range(7, 40)); h = 8'($urandom_range(7, 40)); end
				5: begin w = 8'd3; h = 8'd6; end
				6: begin w = 8'd255; h = 8'd1; end
				default: begin w = 8'd40; h = 8'd255; end
			endcase
			reconfigure(w, h);
			case (p % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 51; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 51; end
				default: begin gap_pct = 30; stall_pct = 30; end
			endcase
			base = work_items;
			while (work_items - base < PHASE_ITEMS) begin
				// now and then a slot with nothing to draw
				if ($urandom_range(0, 9) == 0)
					send_item(make_item(CMD_SLOT, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
						16'($urandom_range(0, 16'hFFFF))));
				draw_ring(random_start(screen_w <= 6 && screen_h <= 6),
					($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 7)) : -1);
			end
		end

		// Wind down: drop valid, wait for the last due words, then a short tail
		gap_pct = 0;
		stall_pct = 0;
		quiet_inputs();
		waited = 0;
		while (outstanding != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (outstanding != 0)
			$display("%0d display words never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/rrs_pkg.sv
design/rrs_pixel.sv
design/rrs_seq.sv
design/ring_raster_stream.sv
design/rrs_checker.sv
verif/ring_stream_checker.sv
verif/tb.sv
